>>> rtl/utf16_to_utf8_transcoder_defines.svh
// ----------------------------------------------------------------------------
// utf16_to_utf8_transcoder assertion macros
// shared property wrappers for the transcoder rtl
// ----------------------------------------------------------------------------
`ifndef UTF16_TO_UTF8_TRANSCODER_DEFINES_SVH
`define UTF16_TO_UTF8_TRANSCODER_DEFINES_SVH

// condition holds on every clock outside reset
`define U16U8_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("u16u8 assertion failed");

// consequent holds in the cycle after the antecedent
`define U16U8_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("u16u8 sequence assertion failed");

`endif

>>> rtl/u16u8_pkg.sv
// ----------------------------------------------------------------------------
// u16u8_pkg
// types and constants shared by the utf-16 to utf-8 transcoder
// ----------------------------------------------------------------------------
package u16u8_pkg;

    // unit ranges
    localparam logic [15:0] ONE_BYTE_LIMIT = 16'h0080;
    localparam logic [15:0] TWO_BYTE_LIMIT = 16'h0800;
    localparam logic [15:0] SURR_LOW       = 16'hD800;
    localparam logic [15:0] SURR_HIGH      = 16'hDFFF;

    // lead and continuation markers
    localparam logic [7:0] LEAD2_MARK = 8'hC0;
    localparam logic [7:0] LEAD3_MARK = 8'hE0;
    localparam logic [7:0] CONT_MARK  = 8'h80;
    localparam logic [7:0] CONT_MASK  = 8'h3F;
    localparam logic [7:0] SUBST_BYTE = 8'h3F; // '?'

    // byte counts of a job
    localparam logic [1:0] CNT_ONE   = 2'd1;
    localparam logic [1:0] CNT_TWO   = 2'd2;
    localparam logic [1:0] CNT_THREE = 2'd3;

    // default depth of the job queue
    localparam int QUEUE_DEPTH = 2;

    // one classified unit, bytes in send order from index 0
    typedef struct packed {
        logic [2:0][7:0] bytes;
        logic [1:0]      count;
        logic            has_byte;
        logic            eot;
    } t_job;

endpackage

>>> rtl/u16u8_front.sv
// ----------------------------------------------------------------------------
// u16u8_front
// accepts code units, tracks the stop state and builds byte jobs
// ----------------------------------------------------------------------------
`include "utf16_to_utf8_transcoder_defines.svh"

module u16u8_front
    import u16u8_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [15:0] i_code_unit,
    input  logic        i_last_unit,
    input  logic        i_q_full,
    output logic        o_push,
    output t_job        o_job
);

    logic r_stopped;
    logic n_stopped;
    logic accept;
    logic is_zero;
    logic [7:0] cont_lo;
    logic [7:0] cont_mid;

    assign o_in_ready = !i_q_full;
    assign accept     = i_in_valid && o_in_ready;
    assign is_zero    = (i_code_unit == '0);
    assign o_push     = accept && !r_stopped;

    // continuation bytes
    assign cont_lo  = CONT_MARK | ({2'b00, i_code_unit[5:0]} & CONT_MASK);
    assign cont_mid = CONT_MARK | ({2'b00, i_code_unit[11:6]} & CONT_MASK);

    // classify the unit
    always_comb begin
        o_job          = '0;
        o_job.has_byte = 1'b1;
        o_job.eot      = i_last_unit;
        priority if (is_zero) begin
            o_job.count    = CNT_ONE;
            o_job.has_byte = 1'b0;
            o_job.eot      = 1'b1;
        end else if (i_code_unit < ONE_BYTE_LIMIT) begin
            o_job.bytes[0] = i_code_unit[7:0];
            o_job.count    = CNT_ONE;
        end else if (i_code_unit < TWO_BYTE_LIMIT) begin
            o_job.bytes[0] = LEAD2_MARK | {3'b000, i_code_unit[10:6]};
            o_job.bytes[1] = cont_lo;
            o_job.count    = CNT_TWO;
        end else if (i_code_unit >= SURR_LOW && i_code_unit <= SURR_HIGH) begin
            o_job.bytes[0] = SUBST_BYTE;
            o_job.count    = CNT_ONE;
        end else begin
            o_job.bytes[0] = LEAD3_MARK | {4'b0000, i_code_unit[15:12]};
            o_job.bytes[1] = cont_mid;
            o_job.bytes[2] = cont_lo;
            o_job.count    = CNT_THREE;
        end
    end

    // stop state: set by a zero unit inside the field, cleared by the field end
    always_comb begin
        n_stopped = r_stopped;
        if (accept) begin
            if (r_stopped) begin
                n_stopped = !i_last_unit;
            end else if (is_zero && !i_last_unit) begin
                n_stopped = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stopped <= 1'b0;
        end else begin
            r_stopped <= n_stopped;
        end
    end

    // a zero unit inside the field stops the text
    `U16U8_ASSERT_NEXT(a_zero_stops, i_clk, i_rst_n, o_push && is_zero && !i_last_unit, r_stopped)

endmodule

>>> rtl/u16u8_queue.sv
// ----------------------------------------------------------------------------
// u16u8_queue
// short job queue between the front and the back
// ----------------------------------------------------------------------------
`include "utf16_to_utf8_transcoder_defines.svh"

module u16u8_queue
    import u16u8_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    output logic o_full,
    input  logic i_pop,
    output t_job o_job,
    output logic o_nonempty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_job          r_mem [DEPTH];
    logic [AW-1:0] r_wr;
    logic [AW-1:0] r_rd;
    logic [CW-1:0] r_cnt;
    logic [AW-1:0] n_wr;
    logic [AW-1:0] n_rd;
    logic [CW-1:0] n_cnt;

    assign o_full     = (r_cnt == CW'(DEPTH));
    assign o_nonempty = (r_cnt != '0);
    assign o_job      = r_mem[r_rd];

    // pointer wrap
    assign n_wr = (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + AW'(1);
    assign n_rd = (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + AW'(1);

    // fill level
    always_comb begin
        unique case ({i_push, i_pop})
            2'b10:   n_cnt = r_cnt + CW'(1);
            2'b01:   n_cnt = r_cnt - CW'(1);
            default: n_cnt = r_cnt;
        endcase
    end

    // entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= n_wr;
            end
            if (i_pop) begin
                r_rd <= n_rd;
            end
            r_cnt <= n_cnt;
        end
    end

    `U16U8_ASSERT(a_no_overflow, i_clk, i_rst_n, !(i_push && o_full))
    `U16U8_ASSERT(a_no_underflow, i_clk, i_rst_n, !(i_pop && !o_nonempty))

endmodule

>>> rtl/u16u8_back.sv
// ----------------------------------------------------------------------------
// u16u8_back
// serializes queued jobs onto the byte-wide result channel
// ----------------------------------------------------------------------------
`include "utf16_to_utf8_transcoder_defines.svh"

module u16u8_back
    import u16u8_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_q_nonempty,
    input  t_job       i_job,
    output logic       o_pop,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [7:0] o_out_byte,
    output logic       o_byte_valid,
    output logic       o_last_of_run,
    output logic       o_end_of_text
);

    logic       r_busy;
    logic [1:0] r_idx;
    t_job       r_job;
    logic       n_busy;
    logic [1:0] n_idx;
    logic       is_last;
    logic       take;

    assign is_last = (r_idx == r_job.count - 2'd1);
    assign take    = r_busy && i_out_ready;
    assign o_pop   = i_q_nonempty && (!r_busy || (take && is_last));

    // result fields from the held job
    assign o_out_valid   = r_busy;
    assign o_out_byte    = r_job.bytes[r_idx];
    assign o_byte_valid  = r_job.has_byte;
    assign o_last_of_run = is_last;
    assign o_end_of_text = is_last && r_job.eot;

    // byte index and busy flag
    always_comb begin
        n_busy = r_busy;
        n_idx  = r_idx;
        if (o_pop) begin
            n_busy = 1'b1;
            n_idx  = '0;
        end else if (take) begin
            if (is_last) begin
                n_busy = 1'b0;
                n_idx  = '0;
            end else begin
                n_idx = r_idx + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_job <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= '0;
        end else begin
            r_busy <= n_busy;
            r_idx  <= n_idx;
        end
    end

    `U16U8_ASSERT(a_idx_in_job, i_clk, i_rst_n, !r_busy || (r_idx < r_job.count))
    `U16U8_ASSERT_NEXT(a_run_continues, i_clk, i_rst_n, take && !is_last, r_busy && (r_idx != '0))

endmodule

>>> rtl/utf16_to_utf8_transcoder.sv
// ----------------------------------------------------------------------------
// utf16_to_utf8_transcoder
// big-endian utf-16 code units in, utf-8 bytes out (basic plane only)
// ----------------------------------------------------------------------------
// One code unit is taken per word on the input channel and turned into one,
// two or three utf-8 bytes, a '?' for a surrogate half, or a single end marker
// (byte_valid low) for a zero unit; after a zero unit the following units are
// dropped up to and including the one flagged as the last of the field.
// Results leave one per cycle while the output is ready, on a single byte
// lane; a unit yields 1 to 3 results: 3 for units from 0x800 up other than
// surrogate halves, 1 for a surrogate half or a zero unit; dropped units yield
// none. The front accepts one unit per cycle while the job queue (QDEPTH
// entries) has room, so the sustained rate is set by the byte serializer in
// the back. When the back is idle, an accepted unit is written to the queue,
// then popped into the back's held job, from which its first result is sent.
// No clearing pass after reset; the input is ready once reset is released.
// ----------------------------------------------------------------------------
module utf16_to_utf8_transcoder
    import u16u8_pkg::*;
#(
    parameter int QDEPTH = QUEUE_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [15:0] i_code_unit,
    input  logic        i_last_unit,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [7:0]  o_out_byte,
    output logic        o_byte_valid,
    output logic        o_last_of_run,
    output logic        o_end_of_text
);

    logic q_full;
    logic q_nonempty;
    logic push;
    logic pop;
    t_job push_job;
    t_job pop_job;

    // classify and filter
    u16u8_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_code_unit (i_code_unit),
        .i_last_unit (i_last_unit),
        .i_q_full    (q_full),
        .o_push      (push),
        .o_job       (push_job)
    );

    // decoupling queue
    u16u8_queue #(
        .DEPTH (QDEPTH)
    ) u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_job      (push_job),
        .o_full     (q_full),
        .i_pop      (pop),
        .o_job      (pop_job),
        .o_nonempty (q_nonempty)
    );

    // byte serializer
    u16u8_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_nonempty  (q_nonempty),
        .i_job         (pop_job),
        .o_pop         (pop),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_out_byte    (o_out_byte),
        .o_byte_valid  (o_byte_valid),
        .o_last_of_run (o_last_of_run),
        .o_end_of_text (o_end_of_text)
    );

endmodule
